### src/mnorm_pkg.sv
// mnorm_pkg: shared widths, defaults and types for the matrix norm block
// no dependencies; imported by matrix_one_and_infinity_norm and its bench

package mnorm_pkg;

  localparam int SUM_BITS = 22;
  localparam int CFG_BITS = 7;

  localparam int DEF_MAX_ROWS     = 64;
  localparam int DEF_MAX_COLUMNS  = 64;
  localparam int DEF_ELEMENT_BITS = 16;

  localparam logic [SUM_BITS-1:0] SUM_LIMIT = '1;

  typedef enum logic [0:0] {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] column_norm;
    logic [SUM_BITS-1:0] row_norm;
  } result_t;

endpackage

### src/matrix_one_and_infinity_norm.sv
// matrix_one_and_infinity_norm: top level, streaming one-norm and infinity-norm
// depends on mnorm_pkg and mnorm_ram
//
// Elements arrive in row-major order, one item per clock while element_stall is low, and
// can be taken back to back with no gaps inside or between matrices. Each element costs
// one read-modify-write of the column-sum memory (registered read, so the update is
// written in the cycle after the element is taken; a repeat of the same column in the next
// cycle is forwarded). The result for a matrix passes the update stage into a two-entry
// output queue, which element_stall guards against overflow. A write to either shape
// register abandons the matrix in progress. No clearing pass is needed after reset.

module matrix_one_and_infinity_norm #(
  parameter int MAX_ROWS     = mnorm_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS  = mnorm_pkg::DEF_MAX_COLUMNS,
  parameter int ELEMENT_BITS = mnorm_pkg::DEF_ELEMENT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  mnorm_pkg::reg_index_t               cfg_index,
  input  logic [mnorm_pkg::CFG_BITS-1:0]      cfg_data,
  input  logic                                element_valid,
  output logic                                element_stall,
  input  logic signed [ELEMENT_BITS-1:0]      element,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [mnorm_pkg::SUM_BITS-1:0]      column_norm,
  output logic [mnorm_pkg::SUM_BITS-1:0]      row_norm
);

  import mnorm_pkg::*;

  localparam int EB  = ELEMENT_BITS;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int CNW = $clog2(MAX_COLUMNS + 1);
  localparam int AW  = ((EB > SUM_BITS) ? EB : SUM_BITS) + 1;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [EB-1:0] b);
    logic [AW-1:0] s;
    s = AW'(a) + AW'(b);
    return (s > AW'(SUM_LIMIT)) ? SUM_LIMIT : s[SUM_BITS-1:0];
  endfunction

  // configuration
  logic [CFG_BITS-1:0] row_count;
  logic [CFG_BITS-1:0] column_count;
  logic [RNW-1:0]      rows_eff;
  logic [CNW-1:0]      cols_eff;

  // front stage
  logic [RW-1:0]       row_pos;
  logic [CW-1:0]       col_pos;
  logic [SUM_BITS-1:0] cur_row_sum;
  logic [SUM_BITS-1:0] best_row;
  logic [EB-1:0]       elem_u;
  logic [EB-1:0]       mag;
  logic                accept;
  logic                row_last;
  logic                col_last;
  logic                mat_last;
  logic [SUM_BITS-1:0] row_total;
  logic [SUM_BITS-1:0] best_row_cand;

  // update stage
  logic                s1_valid;
  logic [CW-1:0]       s1_col;
  logic [EB-1:0]       s1_mag;
  logic                s1_first_row;
  logic                s1_last_row;
  logic                s1_last;
  logic [SUM_BITS-1:0] s1_row_norm;
  logic                fwd_hit;
  logic [SUM_BITS-1:0] fwd_data;
  logic [SUM_BITS-1:0] ram_rdata;
  logic [SUM_BITS-1:0] col_base;
  logic [SUM_BITS-1:0] colsum;
  logic [SUM_BITS-1:0] best_col;
  logic [SUM_BITS-1:0] best_col_cand;
  logic                push;
  result_t             push_item;

  // output queue
  result_t             q0;
  result_t             q1;
  logic [1:0]          occ;
  logic [1:0]          occ_left;
  logic                pop;

  always_comb begin
    if (row_count == '0) begin
      rows_eff = RNW'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      rows_eff = RNW'(MAX_ROWS);
    end else begin
      rows_eff = RNW'(row_count);
    end
    if (column_count == '0) begin
      cols_eff = CNW'(1);
    end else if (32'(column_count) > MAX_COLUMNS) begin
      cols_eff = CNW'(MAX_COLUMNS);
    end else begin
      cols_eff = CNW'(column_count);
    end
  end

  assign elem_u        = element;
  assign mag           = elem_u[EB-1] ? EB'(~elem_u + 1'b1) : elem_u;
  assign accept        = element_valid && !element_stall;
  assign row_last      = (RNW'(row_pos) + RNW'(1)) == rows_eff;
  assign col_last      = (CNW'(col_pos) + CNW'(1)) == cols_eff;
  assign mat_last      = row_last && col_last;
  assign row_total     = sat_add(cur_row_sum, mag);
  assign best_row_cand = (row_total > best_row) ? row_total : best_row;

  assign pop           = result_valid && !result_stall;
  assign occ_left      = occ - {1'b0, pop};
  assign element_stall = (occ_left == 2'd2) || (occ_left == 2'd1 && s1_valid && s1_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CFG_BITS'(1);
      column_count <= CFG_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row_pos     <= '0;
      col_pos     <= '0;
      cur_row_sum <= '0;
      best_row    <= '0;
      s1_valid    <= 1'b0;
      fwd_hit     <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd_hit  <= accept && s1_valid && (s1_col == col_pos);
      if (accept) begin
        if (col_last) begin
          col_pos     <= '0;
          cur_row_sum <= '0;
          if (row_last) begin
            row_pos  <= '0;
            best_row <= '0;
          end else begin
            row_pos  <= row_pos + 1'b1;
            best_row <= best_row_cand;
          end
        end else begin
          col_pos     <= col_pos + 1'b1;
          cur_row_sum <= row_total;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= colsum;
    if (accept) begin
      s1_col       <= col_pos;
      s1_mag       <= mag;
      s1_first_row <= (row_pos == '0);
      s1_last_row  <= row_last;
      s1_last      <= mat_last;
      s1_row_norm  <= best_row_cand;
    end
  end

  mnorm_ram #(
    .WIDTH(SUM_BITS),
    .DEPTH(MAX_COLUMNS)
  ) u_column_sums (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(colsum),
    .raddr(col_pos),
    .rdata(ram_rdata)
  );

  assign col_base      = s1_first_row ? '0 : (fwd_hit ? fwd_data : ram_rdata);
  assign colsum        = sat_add(col_base, s1_mag);
  assign best_col_cand = (s1_last_row && colsum > best_col) ? colsum : best_col;
  assign push          = s1_valid && s1_last;

  always_comb begin
    push_item.column_norm = best_col_cand;
    push_item.row_norm    = s1_row_norm;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      best_col <= '0;
    end else if (s1_valid) begin
      best_col <= s1_last ? '0 : best_col_cand;
    end
  end

  // two-entry result queue, q0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_left + {1'b0, push};
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (occ == 2'd2) begin
        q0 <= q1;
        q1 <= push_item;
      end else begin
        q0 <= push_item;
      end
    end else if (push) begin
      if (occ == 2'd0) begin
        q0 <= push_item;
      end else begin
        q1 <= push_item;
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

  assign result_valid = (occ != 2'd0);
  assign column_norm  = q0.column_norm;
  assign row_norm     = q0.row_norm;

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !(occ == 2'd2 && !pop))
    else $error("result queue overflow");

  a_stage_follows_accept: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(accept))
    else $error("update stage valid without an accepted item");

  a_matrix_clear: assert property (@(posedge clk) disable iff (rst || cfg_write)
    accept && mat_last |=> row_pos == '0 && col_pos == '0 && cur_row_sum == '0)
    else $error("running state not cleared after last element");

endmodule

### src/mnorm_ram.sv
// mnorm_ram: generic single write port ram with one registered read port
// no dependencies; holds the per-column sums

module mnorm_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### bench/matrix_one_and_infinity_norm_test.sv
`timescale 1ns / 100ps
// matrix_one_and_infinity_norm_test: self-checking bench for the streaming matrix norm block
// predicts one-norm and infinity-norm per matrix and checks each result in order
// depends on mnorm_pkg and matrix_one_and_infinity_norm

module matrix_one_and_infinity_norm_test;
  import mnorm_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  reg_index_t                cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;
  logic                      element_valid;
  logic                      element_stall;
  logic signed [15:0]        element;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic [SUM_BITS-1:0]       column_norm;
  logic [SUM_BITS-1:0]       row_norm;

  logic                      no_idling;
  int                        mismatches;
  int                        elements_sent;
  int                        quiet_cycles;

  logic [CFG_BITS-1:0]       row_setting;
  logic [CFG_BITS-1:0]       column_setting;
  logic [SUM_BITS-1:0]       column_totals [DEF_MAX_COLUMNS];
  logic [SUM_BITS-1:0]       running_row_total;
  logic [SUM_BITS-1:0]       best_row_total;
  logic [SUM_BITS-1:0]       best_column_total;
  int                        row_index;
  int                        column_index;
  result_t                   pending_norms [$];

  matrix_one_and_infinity_norm dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_valid (element_valid),
    .element_stall (element_stall),
    .element       (element),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .column_norm   (column_norm),
    .row_norm      (row_norm)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    result_stall <= !no_idling && ($urandom_range(99) < 37);
  end

  function automatic int effective_shape(input logic [CFG_BITS-1:0] value, input int limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return int'(value);
  endfunction

  function automatic logic [SUM_BITS-1:0] saturating_add(input logic [SUM_BITS-1:0] a,
                                                        input logic [16:0] b);
    logic [SUM_BITS:0] total;
    total = {1'b0, a} + b;
    return (total > SUM_LIMIT) ? SUM_LIMIT : total[SUM_BITS-1:0];
  endfunction

  function automatic logic signed [15:0] random_element();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 16'h8000;
    if (pick < 16) return 16'h7fff;
    if (pick < 22) return 16'h0000;
    if (pick < 28) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic logic [CFG_BITS-1:0] random_shape_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return CFG_BITS'($urandom_range(1, 6));
    if (pick < 85) return ($urandom_range(1) == 0) ? '0 : CFG_BITS'($urandom_range(65, 127));
    if (pick < 92) return CFG_BITS'($urandom_range(7, 16));
    return CFG_BITS'($urandom_range(33, 64));
  endfunction

  task automatic clear_running_norms();
    running_row_total = '0;
    best_row_total = '0;
    best_column_total = '0;
    row_index = 0;
    column_index = 0;
  endtask

  task automatic accumulate_element(input logic signed [15:0] value);
    int rows;
    int cols;
    int signed_value;
    logic [16:0] magnitude;
    logic [SUM_BITS-1:0] column_total;
    result_t norms;
    rows = effective_shape(row_setting, DEF_MAX_ROWS);
    cols = effective_shape(column_setting, DEF_MAX_COLUMNS);
    signed_value = int'(value);
    magnitude = (signed_value < 0) ? 17'(-signed_value) : 17'(signed_value);
    if (column_index >= cols) column_index = 0;
    if (row_index >= rows) row_index = 0;
    if (row_index == 0) column_total = saturating_add('0, magnitude);
    else column_total = saturating_add(column_totals[column_index], magnitude);
    column_totals[column_index] = column_total;
    running_row_total = saturating_add(running_row_total, magnitude);
    if (row_index + 1 == rows && column_total > best_column_total)
      best_column_total = column_total;
    if (column_index + 1 == cols) begin
      if (running_row_total > best_row_total) best_row_total = running_row_total;
      running_row_total = '0;
      column_index = 0;
      if (row_index + 1 == rows) begin
        norms.column_norm = best_column_total;
        norms.row_norm = best_row_total;
        pending_norms.push_back(norms);
        clear_running_norms();
      end else begin
        row_index++;
      end
    end else begin
      column_index++;
    end
  endtask

  task automatic report_mismatch(input string message);
    $display("mismatch at %0t: %s", $realtime, message);
    mismatches++;
  endtask

  task automatic drive_element(input logic signed [15:0] value);
    while (!no_idling && $urandom_range(99) < 37) begin
      element_valid <= 1'b0;
      @(negedge clk);
    end
    element_valid <= 1'b1;
    element <= value;
    do @(posedge clk); while (element_stall);
    accumulate_element(value);
    elements_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_elements(input int count);
    for (int i = 0; i < count; i++) drive_element(random_element());
  endtask

  task automatic write_shape_register(input reg_index_t index,
                                      input logic [CFG_BITS-1:0] value);
    element_valid <= 1'b0;
    while (pending_norms.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    if (index == REG_ROW_COUNT) row_setting = value;
    else column_setting = value;
    clear_running_norms();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_shape(input logic [CFG_BITS-1:0] rows, input logic [CFG_BITS-1:0] cols);
    write_shape_register(REG_ROW_COUNT, rows);
    write_shape_register(REG_COLUMN_COUNT, cols);
  endtask

  task automatic test_single_element_shape();
    drive_element(16'h0000);
    drive_element(16'h7fff);
    drive_element(16'h8000);
    drive_element(16'hffff);
  endtask

  task automatic test_zero_shape_registers();
    set_shape('0, '0);
    drive_element(16'h0001);
    drive_element(16'h8000);
  endtask

  task automatic test_mixed_extremes();
    set_shape(7'd2, 7'd3);
    drive_element(16'h8000);
    drive_element(16'h7fff);
    drive_element(16'h0000);
    drive_element(16'hffff);
    drive_element(16'h0001);
    drive_element(16'h8000);
  endtask

  task automatic test_tied_sums();
    set_shape(7'd2, 7'd2);
    drive_element(16'sd5);
    drive_element(-16'sd5);
    drive_element(-16'sd5);
    drive_element(16'sd5);
  endtask

  task automatic test_abandoned_matrix();
    set_shape(7'd3, 7'd3);
    drive_element(16'sd100);
    drive_element(-16'sd200);
    drive_element(16'sd300);
    set_shape(7'd1, 7'd2);
    drive_element(16'sd7);
    drive_element(-16'sd9);
  endtask

  task automatic test_largest_shapes();
    set_shape(7'd127, 7'd1);
    for (int i = 0; i < DEF_MAX_ROWS; i++) drive_element(16'h8000);
    set_shape(7'd1, 7'd64);
    for (int i = 0; i < DEF_MAX_COLUMNS; i++) drive_element(16'h8000);
  endtask

  task automatic test_back_to_back();
    no_idling = 1'b1;
    set_shape(7'd3, 7'd4);
    send_random_elements(36);
    set_shape(7'd1, 7'd1);
    send_random_elements(10);
    no_idling = 1'b0;
  endtask

  task automatic test_random_shapes();
    logic [CFG_BITS-1:0] rows;
    logic [CFG_BITS-1:0] cols;
    int matrix_size;
    while (elements_sent < 550) begin
      rows = random_shape_value();
      cols = random_shape_value();
      if (effective_shape(rows, DEF_MAX_ROWS) * effective_shape(cols, DEF_MAX_COLUMNS) > 128)
        cols = CFG_BITS'($urandom_range(1, 2));
      if ($urandom_range(1) == 0) begin
        set_shape(rows, cols);
      end else begin
        write_shape_register(REG_COLUMN_COUNT, cols);
        write_shape_register(REG_ROW_COUNT, rows);
      end
      matrix_size = effective_shape(rows, DEF_MAX_ROWS) * effective_shape(cols, DEF_MAX_COLUMNS);
      repeat ($urandom_range(1, 3)) send_random_elements(matrix_size);
      // partial matrix, dropped by the next register write
      if (matrix_size > 1 && $urandom_range(99) < 10)
        send_random_elements($urandom_range(1, matrix_size - 1));
    end
  endtask

  task automatic drain_results();
    element_valid <= 1'b0;
    while (pending_norms.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_norms.size() == 0) begin
        report_mismatch($sformatf("unexpected result column %0d row %0d",
                                  column_norm, row_norm));
      end else begin
        want = pending_norms.pop_front();
        if (column_norm !== want.column_norm)
          report_mismatch($sformatf("column_norm %0d, want %0d", column_norm, want.column_norm));
        if (row_norm !== want.row_norm)
          report_mismatch($sformatf("row_norm %0d, want %0d", row_norm, want.row_norm));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (element_valid && !element_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("matrix_one_and_infinity_norm verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_ROW_COUNT;
    cfg_data = '0;
    element_valid = 1'b0;
    element = '0;
    no_idling = 1'b0;
    elements_sent = 0;
    row_setting = 7'd1;
    column_setting = 7'd1;
    for (int i = 0; i < DEF_MAX_COLUMNS; i++) column_totals[i] = '0;
    clear_running_norms();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_single_element_shape();
    test_zero_shape_registers();
    test_mixed_extremes();
    test_tied_sums();
    test_abandoned_matrix();
    test_largest_shapes();
    test_back_to_back();
    test_random_shapes();
    drain_results();
    if (mismatches == 0) begin
      $display("matrix_one_and_infinity_norm verification clean");
    end else begin
      $display("matrix_one_and_infinity_norm verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/mnorm_pkg.sv
src/mnorm_ram.sv
src/matrix_one_and_infinity_norm.sv
bench/matrix_one_and_infinity_norm_test.sv
